// File: rtl/mm_pkg.sv
package mm_pkg;

	localparam int MAX_DIM = 8;
	localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int CNT_W = $clog2(MAX_DIM);
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int SIZE_W = 2 * DIM_W;
	localparam int ELEM_W = 16;
	localparam int PROD_W = 2 * ELEM_W;
	localparam int ACC_W = 36;
	localparam int CFG_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int OP_W = 2;

	localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
	localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// Tag that travels alongside a store read through the MAC pipeline
	typedef struct packed {
		logic vld;
		logic first;
		logic lastp;
	} mac_tag_t;

	typedef struct packed {
		logic done;
		logic signed [ACC_W-1:0] acc;
	} mac_status_t;

	// Zero acts as one, anything above MAX_DIM acts as MAX_DIM
	function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] raw);
		logic [DIM_W-1:0] res;
		begin
			if (raw == '0) begin
				res = DIM_W'(1);
			end else if (32'(raw) > MAX_DIM) begin
				res = DIM_W'(MAX_DIM);
			end else begin
				res = DIM_W'(raw);
			end
			return res;
		end
	endfunction

endpackage

// File: rtl/matrix_multiply.sv
// Fixed-point matrix multiply C = A * B with A rows_a x inner_dim and B inner_dim x cols_b,
// elements signed Q8.8, results exact signed Q16.16 in 36 bits. Load items (operation 0/1)
// write one element at a row-major index; indexes outside the current
// matrix size are dropped. A compute item (operation 2) streams rows_a*cols_b results in
// row-major order with last set on the final one. Each result takes inner_dim reads, one per
// cycle from each store into a single multiplier and accumulator, then drains through the
// store read, product and accumulator registers before it is emitted. A compute holds the
// input, through any output stall, until its last result is emitted.
// Dimension registers take 0 as 1 and values above 8 as 8; entries keep their flat index when
// dimensions change. Store entries never written read as unknown.
module matrix_multiply (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [mm_pkg::CFG_W-1:0]             cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [mm_pkg::OP_W-1:0]              operation,
	input  logic [5:0]                           element_index,
	input  logic signed [mm_pkg::ELEM_W-1:0]     value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [2:0]                           row,
	output logic [2:0]                           col,
	output logic signed [mm_pkg::ACC_W-1:0]      product_value,
	output logic                                 last
);

	mm_pkg::state_t state_q, state_d;

	logic [mm_pkg::DIM_W-1:0] rows_q, inner_q, cols_q;
	logic [mm_pkg::CNT_W-1:0] i_q, j_q, p_q;
	logic [mm_pkg::ADDR_W-1:0] a_row_q, a_addr_q, b_addr_q;
	logic [mm_pkg::ADDR_W-1:0] next_a_row, next_j_ext;
	logic [mm_pkg::CNT_W-1:0] next_i, next_j;

	logic in_fire, out_slot, emit_fire;
	logic last_p, last_j, last_elem;
	logic [mm_pkg::SIZE_W-1:0] size_a, size_b;
	logic [mm_pkg::SIZE_W-1:0] idx_ext;
	logic a_we, b_we;
	logic issue;

	mm_pkg::mac_tag_t tag_d, tag_s1;
	mm_pkg::mac_status_t mac_st;
	logic signed [mm_pkg::ELEM_W-1:0] a_rdata, b_rdata;

	logic out_valid_q, out_last_q;
	logic [2:0] out_row_q, out_col_q;
	logic signed [mm_pkg::ACC_W-1:0] out_val_q;

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= mm_pkg::DIM_W'(1);
			inner_q <= mm_pkg::DIM_W'(1);
			cols_q <= mm_pkg::DIM_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				mm_pkg::REG_ROWS_A: rows_q <= mm_pkg::eff_dim(cfg_data);
				mm_pkg::REG_INNER_DIM: inner_q <= mm_pkg::eff_dim(cfg_data);
				mm_pkg::REG_COLS_B: cols_q <= mm_pkg::eff_dim(cfg_data);
				default: ;
			endcase
		end
	end

	assign in_ready = (state_q == mm_pkg::ST_IDLE);
	assign in_fire = in_valid & in_ready;

	assign size_a = mm_pkg::SIZE_W'(rows_q) * mm_pkg::SIZE_W'(inner_q);
	assign size_b = mm_pkg::SIZE_W'(inner_q) * mm_pkg::SIZE_W'(cols_q);
	assign idx_ext = mm_pkg::SIZE_W'(element_index);

	assign a_we = in_fire & (operation == mm_pkg::OP_LOAD_A) & (idx_ext < size_a);
	assign b_we = in_fire & (operation == mm_pkg::OP_LOAD_B) & (idx_ext < size_b);

	// Loop bookkeeping
	assign last_p = (mm_pkg::DIM_W'(p_q) == inner_q - mm_pkg::DIM_W'(1));
	assign last_j = (mm_pkg::DIM_W'(j_q) == cols_q - mm_pkg::DIM_W'(1));
	assign last_elem = last_j & (mm_pkg::DIM_W'(i_q) == rows_q - mm_pkg::DIM_W'(1));

	assign next_i = last_j ? i_q + mm_pkg::CNT_W'(1) : i_q;
	assign next_j = last_j ? '0 : j_q + mm_pkg::CNT_W'(1);
	assign next_a_row = last_j ? a_row_q + mm_pkg::ADDR_W'(inner_q) : a_row_q;
	assign next_j_ext = mm_pkg::ADDR_W'(next_j);

	assign out_slot = ~out_valid_q | out_ready;
	assign emit_fire = (state_q == mm_pkg::ST_EMIT) & out_slot;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mm_pkg::ST_IDLE: begin
				if (in_fire && operation == mm_pkg::OP_COMPUTE) begin
					state_d = mm_pkg::ST_ISSUE;
				end
			end
			mm_pkg::ST_ISSUE: begin
				if (last_p) begin
					state_d = mm_pkg::ST_DRAIN;
				end
			end
			mm_pkg::ST_DRAIN: begin
				if (mac_st.done) begin
					state_d = mm_pkg::ST_EMIT;
				end
			end
			mm_pkg::ST_EMIT: begin
				if (out_slot) begin
					state_d = last_elem ? mm_pkg::ST_IDLE : mm_pkg::ST_ISSUE;
				end
			end
			default: state_d = mm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		issue = (state_q == mm_pkg::ST_ISSUE);
		tag_d.vld = issue;
		tag_d.first = issue & (p_q == '0);
		tag_d.lastp = issue & last_p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mm_pkg::ST_IDLE;
			tag_s1 <= '0;
			i_q <= '0;
			j_q <= '0;
			p_q <= '0;
			a_row_q <= '0;
			a_addr_q <= '0;
			b_addr_q <= '0;
		end else begin
			state_q <= state_d;
			tag_s1 <= tag_d;
			if (in_fire) begin
				i_q <= '0;
				j_q <= '0;
				p_q <= '0;
				a_row_q <= '0;
				a_addr_q <= '0;
				b_addr_q <= '0;
			end else if (issue && !last_p) begin
				p_q <= p_q + mm_pkg::CNT_W'(1);
				a_addr_q <= a_addr_q + mm_pkg::ADDR_W'(1);
				b_addr_q <= b_addr_q + mm_pkg::ADDR_W'(cols_q);
			end else if (emit_fire) begin
				// advance to the next product element
				i_q <= next_i;
				j_q <= next_j;
				p_q <= '0;
				a_row_q <= next_a_row;
				a_addr_q <= next_a_row;
				b_addr_q <= next_j_ext;
			end
		end
	end

	mm_ram #(
		.WIDTH(mm_pkg::ELEM_W),
		.DEPTH(mm_pkg::STORE_DEPTH)
	) u_a_store (
		.clk  (clk),
		.we   (a_we),
		.waddr(element_index),
		.wdata(value),
		.raddr(a_addr_q),
		.rdata(a_rdata)
	);

	mm_ram #(
		.WIDTH(mm_pkg::ELEM_W),
		.DEPTH(mm_pkg::STORE_DEPTH)
	) u_b_store (
		.clk  (clk),
		.we   (b_we),
		.waddr(element_index),
		.wdata(value),
		.raddr(b_addr_q),
		.rdata(b_rdata)
	);

	mm_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.tag_s1(tag_s1),
		.a_data(a_rdata),
		.b_data(b_rdata),
		.status(mac_st)
	);

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_row_q <= 3'(i_q);
			out_col_q <= 3'(j_q);
			out_val_q <= mac_st.acc;
			out_last_q <= last_elem;
		end
	end

	assign out_valid = out_valid_q;
	assign row = out_row_q;
	assign col = out_col_q;
	assign product_value = out_val_q;
	assign last = out_last_q;

endmodule

// File: rtl/mm_ram.sv
module mm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/mm_mac.sv
module mm_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mm_pkg::mac_tag_t                      tag_s1,
	input  logic signed [mm_pkg::ELEM_W-1:0]      a_data,
	input  logic signed [mm_pkg::ELEM_W-1:0]      b_data,
	output mm_pkg::mac_status_t                   status
);

	mm_pkg::mac_tag_t tag_s2;
	logic signed [mm_pkg::PROD_W-1:0] prod_s2;
	logic signed [mm_pkg::ACC_W-1:0] acc_q;
	logic signed [mm_pkg::ACC_W-1:0] prod_ext;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			tag_s2 <= tag_s1;
			done_q <= tag_s2.vld & tag_s2.lastp;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_data * b_data;
	end

	assign prod_ext = mm_pkg::ACC_W'(prod_s2);

	// Restart the sum on the first term of each dot product
	always_ff @(posedge clk) begin
		if (tag_s2.vld) begin
			acc_q <= tag_s2.first ? prod_ext : acc_q + prod_ext;
		end
	end

	assign status.done = done_q;
	assign status.acc = acc_q;

endmodule
